[rtl/bdte_pkg.sv]
// shared types, constants and helper functions for the bcd date-time to epoch converter
package bdte_pkg;

    // calendar constants
    localparam logic [7:0] YEAR_BASE      = 8'd80;   // two-digit year counts from 1980
    localparam logic [7:0] EPOCH_YEAR     = 8'd70;   // epoch is 1970, years since 1900
    localparam logic [9:0] DAYS_YEAR      = 10'd365;
    localparam logic [9:0] DAYS_LEAP     = 10'd366;
    localparam logic [5:0] HOURS_DAY      = 6'd24;
    localparam logic [5:0] MINUTES_HOUR   = 6'd60;
    localparam logic [5:0] SECONDS_MINUTE = 6'd60;
    localparam logic [5:0] MUL_ONE        = 6'd1;
    localparam logic [3:0] NO_CLOCK_DIGIT = 4'd15;
    localparam logic [7:0] YEAR_MAX       = 8'd99;
    localparam logic [7:0] MONTH_MAX      = 8'd12;
    localparam logic [7:0] DAY_MAX        = 8'd31;
    localparam logic [7:0] HOUR_MAX       = 8'd23;
    localparam logic [7:0] MINUTE_MAX     = 8'd59;
    localparam logic [7:0] SECOND_MAX     = 8'd59;
    localparam logic [3:0] MONTH_FEB      = 4'd1;    // zero-based month index of february

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_CLOCK = 3'd1;
    localparam logic [2:0] ST_YEAR     = 3'd2;
    localparam logic [2:0] ST_MONTH    = 3'd3;
    localparam logic [2:0] ST_DAY      = 3'd4;
    localparam logic [2:0] ST_HOUR     = 3'd5;
    localparam logic [2:0] ST_MINUTE   = 3'd6;
    localparam logic [2:0] ST_SECOND   = 3'd7;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_YEAR  = 5'b00010,
        S_MONTH = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // raw bcd digits of one transaction
    typedef struct packed {
        logic [3:0] second_ones;
        logic [3:0] second_tens;
        logic [3:0] minute_ones;
        logic [3:0] minute_tens;
        logic [3:0] hour_ones;
        logic [3:0] hour_tens;
        logic [3:0] day_ones;
        logic [3:0] day_tens;
        logic [3:0] month_ones;
        logic [3:0] month_tens;
        logic [3:0] year_ones;
        logic [3:0] year_tens;
    } t_digits;

    // converted result
    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic [2:0]  status;
    } t_result;

    // handshake between wrapper and sequencer
    typedef struct packed {
        logic idle;
        logic done;
    } t_ctl;

    // ones + 10 * tens, nibbles taken as they are
    function automatic logic [7:0] pair_value(input logic [3:0] ones, input logic [3:0] tens);
        pair_value = {4'd0, ones} + {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
    endfunction

    // days in a month of a common year, zero-based month index
    function automatic logic [4:0] month_days(input logic [3:0] k);
        case (k)
            4'd0:    month_days = 5'd31;
            4'd1:    month_days = 5'd28;
            4'd2:    month_days = 5'd31;
            4'd3:    month_days = 5'd30;
            4'd4:    month_days = 5'd31;
            4'd5:    month_days = 5'd30;
            4'd6:    month_days = 5'd31;
            4'd7:    month_days = 5'd31;
            4'd8:    month_days = 5'd30;
            4'd9:    month_days = 5'd31;
            4'd10:   month_days = 5'd30;
            4'd11:   month_days = 5'd31;
            default: month_days = 5'd0;
        endcase
    endfunction

endpackage

[rtl/bcd_datetime_to_epoch_seconds.sv]
// top level: bcd rtc date-time to epoch seconds with valid/ready channels
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | i_valid / o_ready   | twelve 4-bit bcd digits, i_second_ones ...
//   output  | o_valid / i_ready   | o_epoch_seconds[31:0], o_status[2:0]
//
// from accept to output valid a transaction makes 10 + two-digit year steps
// of the year walk and one to leave it, month - 1 month steps, one day step,
// three scale steps and one to move the result out, all through one shared
// multiply-add unit; a rejected transaction goes straight to its result.
// reset is synchronous and active low and clears the sequencer and output
// valid. a finished result moves to the output register, so a new transaction
// is accepted while the previous one waits.
module bcd_datetime_to_epoch_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_second_ones,
    input  logic [3:0]  i_second_tens,
    input  logic [3:0]  i_minute_ones,
    input  logic [3:0]  i_minute_tens,
    input  logic [3:0]  i_hour_ones,
    input  logic [3:0]  i_hour_tens,
    input  logic [3:0]  i_day_ones,
    input  logic [3:0]  i_day_tens,
    input  logic [3:0]  i_month_ones,
    input  logic [3:0]  i_month_tens,
    input  logic [3:0]  i_year_ones,
    input  logic [3:0]  i_year_tens,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_epoch_seconds,
    output logic [2:0]  o_status
);
    import bdte_pkg::*;

    t_digits     w_digits;
    t_ctl        w_ctl;
    t_result     w_result;
    logic        w_start, w_take;
    logic        r_out_valid;
    logic [31:0] r_epoch;
    logic [2:0]  r_status;

    // gather digits
    assign w_digits.second_ones = i_second_ones;
    assign w_digits.second_tens = i_second_tens;
    assign w_digits.minute_ones = i_minute_ones;
    assign w_digits.minute_tens = i_minute_tens;
    assign w_digits.hour_ones   = i_hour_ones;
    assign w_digits.hour_tens   = i_hour_tens;
    assign w_digits.day_ones    = i_day_ones;
    assign w_digits.day_tens    = i_day_tens;
    assign w_digits.month_ones  = i_month_ones;
    assign w_digits.month_tens  = i_month_tens;
    assign w_digits.year_ones   = i_year_ones;
    assign w_digits.year_tens   = i_year_tens;

    assign o_ready = w_ctl.idle;
    assign w_start = i_valid && w_ctl.idle;
    assign w_take  = w_ctl.done && (!r_out_valid || i_ready);

    bdte_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_digits (w_digits),
        .i_take   (w_take),
        .o_ctl    (w_ctl),
        .o_result (w_result)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_epoch  <= w_result.epoch_seconds;
            r_status <= w_result.status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_epoch_seconds = r_epoch;
    assign o_status        = r_status;

endmodule

[rtl/bdte_seq.sv]
// sequencer and shared multiply-add unit that accumulate days and seconds
module bdte_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bdte_pkg::t_digits i_digits,
    input  logic              i_take,
    output bdte_pkg::t_ctl    o_ctl,
    output bdte_pkg::t_result o_result
);
    import bdte_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_y, n_y;
    logic [3:0]  r_k, n_k;
    logic [1:0]  r_ph, n_ph;
    logic [2:0]  r_status;
    logic [7:0]  r_lim;
    logic        r_leap;
    logic [7:0]  r_mon, r_day, r_hour, r_min, r_sec;

    // field values of the incoming digits
    logic [7:0] w_sec, w_min, w_hour, w_day, w_mon, w_yr;
    logic [2:0] w_status;

    assign w_sec  = pair_value(i_digits.second_ones, i_digits.second_tens);
    assign w_min  = pair_value(i_digits.minute_ones, i_digits.minute_tens);
    assign w_hour = pair_value(i_digits.hour_ones, i_digits.hour_tens);
    assign w_day  = pair_value(i_digits.day_ones, i_digits.day_tens);
    assign w_mon  = pair_value(i_digits.month_ones, i_digits.month_tens);
    assign w_yr   = pair_value(i_digits.year_ones, i_digits.year_tens);

    // first failing check wins
    always_comb begin
        if (i_digits.second_ones == NO_CLOCK_DIGIT) begin
            w_status = ST_NO_CLOCK;
        end else if (w_yr > YEAR_MAX) begin
            w_status = ST_YEAR;
        end else if (w_mon < 8'd1 || w_mon > MONTH_MAX) begin
            w_status = ST_MONTH;
        end else if (w_day < 8'd1 || w_day > DAY_MAX) begin
            w_status = ST_DAY;
        end else if (w_hour > HOUR_MAX) begin
            w_status = ST_HOUR;
        end else if (w_min > MINUTE_MAX) begin
            w_status = ST_MINUTE;
        end else if (w_sec > SECOND_MAX) begin
            w_status = ST_SECOND;
        end else begin
            w_status = ST_OK;
        end
    end

    // shared multiply-add: acc * mul + add
    logic [5:0]  u_mul;
    logic [9:0]  u_add;
    logic [37:0] w_prod;
    logic [31:0] w_sum;
    logic        w_year_more, w_month_more;

    assign w_year_more  = (r_y < r_lim);
    assign w_month_more = ({4'd0, r_k} + 8'd1 < r_mon);

    always_comb begin
        u_mul = MUL_ONE;
        u_add = 10'd0;
        case (r_state)
            S_YEAR: begin
                u_add = (r_y[1:0] == 2'b00) ? DAYS_LEAP : DAYS_YEAR;
            end
            S_MONTH: begin
                if (w_month_more) begin
                    u_add = {5'd0, month_days(r_k)} +
                            {9'd0, (r_k == MONTH_FEB) && r_leap};
                end else begin
                    u_add = {2'b00, r_day - 8'd1};
                end
            end
            S_SCALE: begin
                case (r_ph)
                    2'd0: begin
                        u_mul = HOURS_DAY;
                        u_add = {2'b00, r_hour};
                    end
                    2'd1: begin
                        u_mul = MINUTES_HOUR;
                        u_add = {2'b00, r_min};
                    end
                    default: begin
                        u_mul = SECONDS_MINUTE;
                        u_add = {2'b00, r_sec};
                    end
                endcase
            end
            default: begin
                u_mul = MUL_ONE;
                u_add = 10'd0;
            end
        endcase
    end

    assign w_prod = r_acc * u_mul;
    assign w_sum  = w_prod[31:0] + {22'd0, u_add};

    // next state and loop counters
    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_y     = r_y;
        n_k     = r_k;
        n_ph    = r_ph;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_acc   = 32'd0;
                    n_y     = EPOCH_YEAR;
                    n_k     = 4'd0;
                    n_ph    = 2'd0;
                    n_state = (w_status == ST_OK) ? S_YEAR : S_DONE;
                end
            end
            S_YEAR: begin
                if (w_year_more) begin
                    n_acc = w_sum;
                    n_y   = r_y + 8'd1;
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                n_acc = w_sum;
                if (w_month_more) begin
                    n_k = r_k + 4'd1;
                end else begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_acc = w_sum;
                n_ph  = r_ph + 2'd1;
                if (r_ph == 2'd2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_y   <= n_y;
        r_k   <= n_k;
        r_ph  <= n_ph;
        if (r_state == S_IDLE && i_start) begin
            r_status <= w_status;
            r_lim    <= YEAR_BASE + w_yr;
            r_leap   <= (w_yr[1:0] == 2'b00);
            r_mon    <= w_mon;
            r_day    <= w_day;
            r_hour   <= w_hour;
            r_min    <= w_min;
            r_sec    <= w_sec;
        end
    end

    assign o_ctl.idle             = (r_state == S_IDLE);
    assign o_ctl.done             = (r_state == S_DONE);
    assign o_result.epoch_seconds = r_acc;
    assign o_result.status        = r_status;

`ifndef SYNTHESIS
    // a rejected transaction reports zero seconds
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status != ST_OK) |-> (r_acc == 32'd0))
        else $error("bad status with nonzero seconds");

    // year walk never passes its limit
    a_year_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (r_y <= r_lim))
        else $error("year counter past limit");

    // month walk stays inside the year
    a_month_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> (r_k < 4'd12))
        else $error("month index out of range");

    // work only starts from idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("start while busy");

    // result is held until taken
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_take) |=> (r_state == S_DONE && $stable(r_acc)))
        else $error("result lost before take");
`endif

endmodule
